[rtl/mps_pkg.sv]
// shared types and constants of the minutia point sorter
package mps_pkg;

    localparam int MaxPoints = 64;

    localparam logic [2:0] KEY_XY      = 3'd0;
    localparam logic [2:0] KEY_YX      = 3'd1;
    localparam logic [2:0] KEY_QUALITY = 3'd2;
    localparam logic [2:0] KEY_ANGLE   = 3'd3;
    localparam logic [2:0] KEY_POLAR   = 3'd4;

    localparam logic CFG_SORT_KEY   = 1'b0;
    localparam logic CFG_DESCENDING = 1'b1;

    // one stored point with its ordering key
    typedef struct packed {
        logic [48:0] key;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] angle;
        logic [7:0]  quality;
        logic [5:0]  idx;
    } rec_t;

    // control handed to every cell
    typedef struct packed {
        logic load;
        logic shift;
        logic desc;
    } cell_ctl_t;

endpackage

[rtl/mps_cell.sv]
// one cell of the insertion chain: keeps a record, pushes the one that sorts later down
module mps_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  mps_pkg::cell_ctl_t ctl,
    input  logic              prev_valid,
    input  mps_pkg::rec_t     prev_rec,
    input  logic              prev_takes,
    input  mps_pkg::rec_t     new_rec,
    input  logic              next_valid,
    input  mps_pkg::rec_t     next_rec,
    output logic              valid,
    output logic              takes,
    output mps_pkg::rec_t     rec
);
    logic          valid_reg, valid_next;
    mps_pkg::rec_t rec_reg, rec_next;
    logic          beats;

    // new record goes before held one only on strict key order (keeps stability)
    assign beats = ctl.desc ? (new_rec.key > rec_reg.key) : (new_rec.key < rec_reg.key);
    assign takes = !valid_reg || beats;

    // insert, shift from predecessor, or drain toward the head
    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctl.load) begin
            if (prev_takes) begin
                valid_next = prev_valid;
                rec_next   = prev_rec;
            end else if (takes) begin
                valid_next = 1'b1;
                rec_next   = new_rec;
            end
        end else if (ctl.shift) begin
            valid_next = next_valid;
            rec_next   = next_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rec_reg <= rec_next;
    end

    assign valid = valid_reg;
    assign rec   = rec_reg;
endmodule

[rtl/mps_div.sv]
// restoring divider for the centroid, one quotient bit per cycle
module mps_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [21:0] dividend,
    input  logic [6:0]  divisor,
    output logic        busy,
    output logic [15:0] quotient
);
    logic [21:0] q_reg, q_next;
    logic [7:0]  r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [7:0]  trial;

    assign trial = {r_reg[6:0], q_reg[21]};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            q_next    = dividend;
            r_next    = 8'd0;
            cnt_next  = 5'd22;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[20:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[20:0], 1'b0};
            end
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg[15:0];
endmodule

[rtl/minutia_point_sorter.sv]
// top level of the minutia point sorter
// Points arrive one per cycle, while the block is loading, into a buffer and
// are accumulated for the centroid. A point marked final closes the set; each
// stored point is then read back and inserted into a chain of compare-and-shift
// cells, by a read step and an insert step per point for keys other than 4.
// For key 4 the centroid is first found by a serial divider: a start step,
// then two divisions, and each point then passes through a read, a squared
// distance and an insert step. Results are then returned one per cycle when
// the consumer is ready. No new point is taken until the set has drained.
module minutia_point_sorter #(
    parameter int MAX_POINTS = mps_pkg::MaxPoints
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_point_x,
    input  logic [15:0] s_point_y,
    input  logic [15:0] s_point_angle,
    input  logic [7:0]  s_point_quality,
    input  logic        s_final_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_x,
    output logic [15:0] m_out_y,
    output logic [15:0] m_out_angle,
    output logic [7:0]  m_out_quality,
    output logic [5:0]  m_arrival_index,
    output logic        m_overflowed,
    output logic        m_last_result
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [2:0] {
        ST_LOAD, ST_CEN, ST_DIVX, ST_DIVY, ST_RD, ST_DIST, ST_INS, ST_OUT
    } state_t;

    state_t        state_reg;
    logic [2:0]    key_reg;
    logic          desc_reg;
    logic [CW-1:0] count_reg, ptr_reg, left_reg;
    logic [21:0]   sumx_reg, sumy_reg;
    logic [15:0]   cx_reg, cy_reg;
    logic          ovf_reg;
    logic [61:0]   mem [MAX_POINTS];
    logic [61:0]   rd_reg;
    logic [31:0]   sqx_reg, sqy_reg;
    mps_pkg::rec_t new_rec;
    logic [15:0]   dx, dy;
    logic          div_start, div_busy;
    logic [15:0]   div_q;
    mps_pkg::cell_ctl_t ctl;

    logic          cv [MAX_POINTS];
    mps_pkg::rec_t cr [MAX_POINTS];
    logic          ct [MAX_POINTS];

    assign cfg_ready = (state_reg == ST_LOAD);
    assign s_ready   = (state_reg == ST_LOAD);

    mps_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(state_reg == ST_CEN ? sumx_reg : sumy_reg),
        .divisor(7'(count_reg)), .busy(div_busy), .quotient(div_q)
    );

    // absolute differences from the centroid
    assign dx = (rd_reg[61:46] >= cx_reg) ? (rd_reg[61:46] - cx_reg)
                                          : (cx_reg - rd_reg[61:46]);
    assign dy = (rd_reg[45:30] >= cy_reg) ? (rd_reg[45:30] - cy_reg)
                                          : (cy_reg - rd_reg[45:30]);

    // key formation for the record being inserted
    always_comb begin
        new_rec.x       = rd_reg[61:46];
        new_rec.y       = rd_reg[45:30];
        new_rec.angle   = rd_reg[29:14];
        new_rec.quality = rd_reg[13:6];
        new_rec.idx     = rd_reg[5:0];
        unique case (key_reg)
            mps_pkg::KEY_YX:      new_rec.key = {17'd0, rd_reg[45:30], rd_reg[61:46]};
            mps_pkg::KEY_QUALITY: new_rec.key = {41'd0, rd_reg[13:6]};
            mps_pkg::KEY_ANGLE:   new_rec.key = {33'd0, rd_reg[29:14]};
            mps_pkg::KEY_POLAR:   new_rec.key = {33'({1'b0, sqx_reg} + {1'b0, sqy_reg}),
                                                 rd_reg[29:14]};
            default:              new_rec.key = {17'd0, rd_reg[61:46], rd_reg[45:30]};
        endcase
    end

    assign ctl.load  = (state_reg == ST_INS);
    assign ctl.shift = (state_reg == ST_OUT) && m_ready;
    assign ctl.desc  = desc_reg;

    // chain of cells; head is cell 0, which presents the next result
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        logic          pv, pt, nv;
        mps_pkg::rec_t pr, nr;
        if (g == 0) begin : g_head
            assign pv = 1'b0;
            assign pt = 1'b0;
            assign pr = new_rec;
        end else begin : g_body
            assign pv = cv[g-1];
            assign pt = ct[g-1];
            assign pr = cr[g-1];
        end
        if (g == MAX_POINTS - 1) begin : g_tail
            assign nv = 1'b0;
            assign nr = new_rec;
        end else begin : g_inner
            assign nv = cv[g+1];
            assign nr = cr[g+1];
        end
        mps_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
            .prev_valid(pv), .prev_rec(pr), .prev_takes(pt), .new_rec(new_rec),
            .next_valid(nv), .next_rec(nr),
            .valid(cv[g]), .takes(ct[g]), .rec(cr[g])
        );
    end

    assign div_start = (state_reg == ST_CEN) || (state_reg == ST_DIVX && !div_busy);

    assign m_valid         = (state_reg == ST_OUT);
    assign m_out_x         = cr[0].x;
    assign m_out_y         = cr[0].y;
    assign m_out_angle     = cr[0].angle;
    assign m_out_quality   = cr[0].quality;
    assign m_arrival_index = cr[0].idx;
    assign m_overflowed    = ovf_reg;
    assign m_last_result   = (left_reg == CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            key_reg   <= mps_pkg::KEY_XY;
            desc_reg  <= 1'b0;
            count_reg <= '0;
            ptr_reg   <= '0;
            left_reg  <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (cfg_valid) begin
                        if (cfg_index == mps_pkg::CFG_SORT_KEY) key_reg <= cfg_data;
                        else desc_reg <= cfg_data[0];
                    end
                    if (s_valid) begin
                        if (count_reg < CW'(MAX_POINTS)) begin
                            count_reg <= count_reg + CW'(1);
                            sumx_reg  <= sumx_reg + 22'(s_point_x);
                            sumy_reg  <= sumy_reg + 22'(s_point_y);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_final_point) begin
                            ptr_reg <= '0;
                            state_reg <= (key_reg == mps_pkg::KEY_POLAR) ? ST_CEN : ST_RD;
                        end
                    end
                end
                ST_CEN: state_reg <= ST_DIVX;
                ST_DIVX: if (!div_busy) begin
                    cx_reg    <= div_q;
                    state_reg <= ST_DIVY;
                end
                ST_DIVY: if (!div_busy) begin
                    cy_reg    <= div_q;
                    state_reg <= ST_RD;
                end
                ST_RD: begin
                    ptr_reg   <= ptr_reg + CW'(1);
                    state_reg <= (key_reg == mps_pkg::KEY_POLAR) ? ST_DIST : ST_INS;
                end
                ST_DIST: state_reg <= ST_INS;
                ST_INS: begin
                    if (ptr_reg == count_reg) begin
                        left_reg  <= count_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_OUT: if (m_ready) begin
                    left_reg <= left_reg - CW'(1);
                    if (left_reg == CW'(1)) begin
                        count_reg <= '0;
                        sumx_reg  <= '0;
                        sumy_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
            endcase
        end
    end

    // point buffer and squared distance registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_valid && count_reg < CW'(MAX_POINTS)) begin
            mem[count_reg[AW-1:0]] <= {s_point_x, s_point_y, s_point_angle,
                                       s_point_quality, 6'(count_reg)};
        end
        if (state_reg == ST_RD) begin
            rd_reg <= mem[ptr_reg[AW-1:0]];
        end
        sqx_reg <= 32'(dx) * 32'(dx);
        sqy_reg <= 32'(dy) * 32'(dy);
    end

    // a result only while the chain head holds a record
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cv[0]) else $error("result without stored record");
    // the set never holds more points than the buffer
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS)) else $error("point count beyond capacity");
    // the last result returns the block to loading
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_result |=> s_ready) else $error("no return to load");
endmodule
